/* hw/rtl/book_cipher_index_decoder_defines.svh */
// Assertion macros used by the book cipher decoder RTL.
`ifndef BOOK_CIPHER_INDEX_DECODER_DEFINES_SVH
`define BOOK_CIPHER_INDEX_DECODER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BCID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BCID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bcid_pkg.sv */
// Types and constants of the book cipher index decoder.
package bcid_pkg;

  localparam int KEY_DEPTH = 4096;
  localparam int ADDR_W    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LEN_W     = $clog2(KEY_DEPTH + 1);
  localparam int ACC_W     = 13;
  localparam int CMP_W     = (LEN_W > ACC_W) ? LEN_W : ACC_W;
  localparam int LETTER_W  = 5;

  localparam logic [ACC_W-1:0] ACC_MAX = 13'd8191;

  localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'
  localparam logic [7:0] CH_LA    = 8'h61; // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7A; // 'z'
  localparam logic [7:0] CH_UA    = 8'h41; // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5A; // 'Z'
  localparam logic [7:0] CH_D0    = 8'h30; // '0'
  localparam logic [7:0] CH_D9    = 8'h39; // '9'
  localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_DECODE  = 2'd2,
    OP_RESTART = 2'd3
  } bcid_op_t;

  // Result stage entry; for a lookup it waits for the key read to come back.
  typedef struct packed {
    logic       lookup;  // take the letter from the key store
    logic       upper;
    logic       bad;
    logic [7:0] chr;     // pass-through byte
  } bcid_res_t;

endpackage

/* hw/rtl/book_cipher_index_decoder.sv */
// Book cipher index decoder: key store load and bracket index decoding.
//
//  channel  dir  handshake          payload
//  in_      in   tvalid/tready      tuser = opcode, tdata = in_byte
//  out_     out  tvalid/tready      tdata = out_char, tuser = bad_index
//
// One item per cycle sustained while in_tready is high; each item is parsed in the cycle it is taken.
// A closing bracket issues one key store read; its letter is formed in the next
// cycle in the result stage, then sits in the output register.
// Reset (rst_n low, synchronous) empties the key and clears the parser.
// A stalled output holds the result stage; input is refused only when both
// the result stage and the output register are full.
module book_cipher_index_decoder
  import bcid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [1:0] in_tuser,   // [1:0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tuser   // [0] bad_index
);

`include "book_cipher_index_decoder_defines.svh"

  // parser state
  logic [LEN_W-1:0] key_len_r,   key_len_nxt;
  logic             in_brk_r,    in_brk_nxt;
  logic             brk_first_r, brk_first_nxt;
  logic             neg_r,       neg_nxt;
  logic             dig_end_r,   dig_end_nxt;
  logic [ACC_W-1:0] acc_r,       acc_nxt;
  logic             err_r,       err_nxt;

  // result stage and output register
  logic      s1_valid_r;
  bcid_res_t s1_r, s1_nxt;
  logic      s1_push;
  logic      s1_adv;
  logic      out_valid_r;
  logic [7:0] out_char_r;
  logic      out_bad_r;

  // key store
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [LETTER_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [LETTER_W-1:0] ram_rdata;

  bcid_op_t   op;
  logic [7:0] c;
  logic [7:0] c_fold;
  logic       accept;
  logic       is_space;
  logic       is_digit;
  logic [16:0] acc_prod;
  logic [CMP_W-1:0] acc_ext;
  logic [CMP_W-1:0] len_ext;
  logic [7:0] letter;

  assign op       = bcid_op_t'(in_tuser);
  assign c        = in_tdata;
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign is_digit = (c >= CH_D0) && (c <= CH_D9);
  assign acc_prod = {{(17-ACC_W){1'b0}}, acc_r} * 17'd10 + {9'd0, c - CH_D0};
  assign acc_ext  = {{(CMP_W-ACC_W){1'b0}}, acc_r};
  assign len_ext  = {{(CMP_W-LEN_W){1'b0}}, key_len_r};
  assign c_fold   = ((c >= CH_UA) && (c <= CH_UZ)) ? c + CASE_GAP : c;

  always_comb begin
    is_space = c inside {CH_SPACE, [CH_TAB:CH_CR]};
  end

  always_comb begin
    key_len_nxt   = key_len_r;
    in_brk_nxt    = in_brk_r;
    brk_first_nxt = brk_first_r;
    neg_nxt       = neg_r;
    dig_end_nxt   = dig_end_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    s1_push       = 1'b0;
    s1_nxt        = '0;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(key_len_r);
    ram_wdata     = LETTER_W'(c_fold - CH_LA);
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(acc_ext);

    if (accept) begin
      case (op)
        OP_CLEAR, OP_RESTART: begin
          if (op == OP_CLEAR) begin
            key_len_nxt = '0;
          end
          in_brk_nxt    = 1'b0;
          brk_first_nxt = 1'b0;
          neg_nxt       = 1'b0;
          dig_end_nxt   = 1'b0;
          acc_nxt       = '0;
          err_nxt       = 1'b0;
        end
        OP_LOAD: begin
          if ((c_fold >= CH_LA) && (c_fold <= CH_LZ) &&
              (key_len_r < LEN_W'(KEY_DEPTH))) begin
            ram_we      = 1'b1;
            key_len_nxt = key_len_r + 1'b1;
          end
        end
        OP_DECODE: begin
          if (!err_r) begin
            if (!in_brk_r) begin
              if (c == CH_OPEN) begin
                in_brk_nxt    = 1'b1;
                brk_first_nxt = 1'b1;
                neg_nxt       = 1'b0;
                dig_end_nxt   = 1'b0;
                acc_nxt       = '0;
              end else begin
                s1_push    = 1'b1;
                s1_nxt.chr = c;
              end
            end else if (c == CH_CLOSE) begin
              in_brk_nxt = 1'b0;
              s1_push    = 1'b1;
              if (acc_ext >= len_ext) begin
                err_nxt    = 1'b1;
                s1_nxt.bad = 1'b1;
              end else begin
                ram_re        = 1'b1;
                s1_nxt.lookup = 1'b1;
                s1_nxt.upper  = neg_r;
              end
            end else begin
              // atoi-style: leading space, one sign, digits up to first non-digit
              if (brk_first_r && is_space) begin
                brk_first_nxt = 1'b1;
              end else if (brk_first_r && (c == CH_MINUS)) begin
                brk_first_nxt = 1'b0;
                neg_nxt       = 1'b1;
              end else if (brk_first_r && (c == CH_PLUS)) begin
                brk_first_nxt = 1'b0;
              end else begin
                brk_first_nxt = 1'b0;
                if (!dig_end_r) begin
                  if (is_digit) begin
                    acc_nxt = (acc_prod > {4'd0, ACC_MAX}) ? ACC_MAX
                                                           : acc_prod[ACC_W-1:0];
                  end else begin
                    dig_end_nxt = 1'b1;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= '0;
      in_brk_r    <= 1'b0;
      brk_first_r <= 1'b0;
      neg_r       <= 1'b0;
      dig_end_r   <= 1'b0;
      acc_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      key_len_r   <= key_len_nxt;
      in_brk_r    <= in_brk_nxt;
      brk_first_r <= brk_first_nxt;
      neg_r       <= neg_nxt;
      dig_end_r   <= dig_end_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
    end
  end

  bcid_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read data is held by the RAM while the result stage stalls (no new read)
  assign letter = {{(8-LETTER_W){1'b0}}, ram_rdata} + CH_LA - (s1_r.upper ? CASE_GAP : 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_push) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_push) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_char_r <= s1_r.bad ? 8'd0 : (s1_r.lookup ? letter : s1_r.chr);
      out_bad_r  <= s1_r.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_bad_r;

  `BCID_ASSERT(a_err_char_zero, out_tvalid && out_tuser |-> out_tdata == 8'd0, "error item carries a non-zero char")
  `BCID_ASSERT(a_key_len_bound, key_len_r <= LEN_W'(KEY_DEPTH), "key length beyond store depth")
  `BCID_ASSERT(a_rd_held, s1_valid_r && s1_r.lookup && !s1_adv |=> $stable(ram_rdata), "key read data lost while stalled")
  `BCID_ASSERT(a_full_stall, s1_valid_r && out_valid_r && !out_tready |-> !in_tready, "item taken with both stages full")
  `BCID_ASSERT(a_err_silent, $past(err_r) && err_r |-> !ram_re, "key read issued while error latched")
  `BCID_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "output valid straight after reset")

endmodule

/* hw/rtl/bcid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bcid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* dv/tb_book_cipher_index_decoder.sv */
// Self-checking testbench for the book cipher index decoder: key loading, bracket decoding.
`timescale 1ns / 100ps

module tb_book_cipher_index_decoder;
  import bcid_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 530;
  localparam int LONG_KEY_LEN    = 240;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    bcid_op_t   op;
    logic [7:0] data;
  } cipher_item_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       bad;
  } decoded_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic [1:0] in_tuser   = OP_CLEAR;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;

  cipher_item_t pending_items[$];
  decoded_t     expected_chars[$];
  decoded_t     got_char;
  cipher_item_t item_out;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_queued      = 0;
  int n_sent        = 0;
  int n_results     = 0;
  int n_bad         = 0;
  int n_mismatch    = 0;
  int cycle_count   = 0;
  int gen_key_len   = 0;  // generator's estimate of the key length

  // predictor state
  logic [LETTER_W-1:0] key_letters [KEY_DEPTH];
  logic [LEN_W-1:0]    key_len;
  logic                in_brk;
  logic                first_pending;
  logic                neg_idx;
  logic                digits_done;
  logic [ACC_W-1:0]    idx_acc;
  logic                err_latched;

  book_cipher_index_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tuser   (in_tuser),   // [1:0] opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_char
    .out_tuser  (out_tuser)   // [0] bad_index
  );

  always #10 clk = ~clk;

  function automatic bit is_key_letter(logic [7:0] b);
    return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ);
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [7:0] random_letter();
    return 8'($urandom_range(0, 25)) + (($urandom_range(0, 1) != 0) ? CH_LA : CH_UA);
  endfunction

  function automatic void clear_parser();
    in_brk        = 1'b0;
    first_pending = 1'b0;
    neg_idx       = 1'b0;
    digits_done   = 1'b0;
    idx_acc       = '0;
    err_latched   = 1'b0;
  endfunction

  // Advance the decoder state by one item; push the character it emits, if any.
  function automatic void decode_step(bcid_op_t op, logic [7:0] b);
    int       v;
    decoded_t res;
    logic [7:0] low;
    case (op)
      OP_CLEAR: begin
        key_len = '0;
        clear_parser();
      end
      OP_LOAD: begin
        if (is_key_letter(b) && key_len < KEY_DEPTH) begin
          low = (b >= CH_UA && b <= CH_UZ) ? b + CASE_GAP : b;
          key_letters[key_len[ADDR_W-1:0]] = LETTER_W'(low - CH_LA);
          key_len = key_len + 1'b1;
        end
      end
      OP_RESTART: clear_parser();
      OP_DECODE: begin
        if (err_latched) return;
        if (!in_brk) begin
          if (b == CH_OPEN) begin
            in_brk        = 1'b1;
            first_pending = 1'b1;
            neg_idx       = 1'b0;
            digits_done   = 1'b0;
            idx_acc       = '0;
          end else begin
            res.chr = b;
            res.bad = 1'b0;
            expected_chars.push_back(res);
          end
        end else if (b != CH_CLOSE) begin
          // atoi-style: blanks, optional sign, digits, then ignore the rest
          if (first_pending) begin
            if (is_blank(b)) return;
            first_pending = 1'b0;
            if (b == CH_MINUS) begin
              neg_idx = 1'b1;
              return;
            end
            if (b == CH_PLUS) return;
          end
          if (!digits_done) begin
            if (b >= CH_D0 && b <= CH_D9) begin
              v = int'(idx_acc) * 10 + int'(b - CH_D0);
              idx_acc = (v > int'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
            end else begin
              digits_done = 1'b1;
            end
          end
        end else begin
          in_brk = 1'b0;
          if (int'(idx_acc) >= int'(key_len) || int'(idx_acc) >= KEY_DEPTH) begin
            err_latched = 1'b1;
            res.chr = '0;
            res.bad = 1'b1;
          end else begin
            res.chr = CH_LA + 8'(key_letters[idx_acc[ADDR_W-1:0]]);
            if (neg_idx) res.chr = res.chr - CASE_GAP;
            res.bad = 1'b0;
          end
          expected_chars.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic queue_item(bcid_op_t op, logic [7:0] b);
    cipher_item_t it;
    it.op   = op;
    it.data = b;
    pending_items.push_back(it);
    n_queued++;
    if (op == OP_CLEAR) gen_key_len = 0;
    else if (op == OP_LOAD && is_key_letter(b) && gen_key_len < KEY_DEPTH) gen_key_len++;
  endtask

  task automatic queue_text(string s);
    foreach (s[i]) queue_item(OP_DECODE, s[i]);
  endtask

  // Clear, then load until n letters have been offered (some non-letters mixed in).
  task automatic queue_key(int n);
    int         got;
    logic [7:0] b;
    got = 0;
    queue_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    while (got < n) begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : random_letter();
      if (is_key_letter(b)) got++;
      queue_item(OP_LOAD, b);
    end
  endtask

  // One bracketed index; oob is set when it should land out of range.
  task automatic queue_bracket(output bit oob);
    int    idx, sel;
    bit    junk;
    string digits;
    junk   = 1'b0;
    idx    = 0;
    digits = "";
    queue_item(OP_DECODE, CH_OPEN);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        sel = $urandom_range(0, 5);
        queue_item(OP_DECODE, (sel == 5) ? CH_SPACE : CH_TAB + 8'(sel));
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 3) queue_item(OP_DECODE, CH_MINUS);
    else if (sel == 3) queue_item(OP_DECODE, CH_PLUS);
    sel = $urandom_range(0, 19);
    case (sel)
      0: ;  // empty bracket reads as index 0
      1: begin
        idx    = $urandom_range(8192, 999999);  // saturates
        digits = $sformatf("%0d", idx);
      end
      2: begin
        junk   = 1'b1;
        digits = $sformatf("%0d", $urandom_range(0, 99));
      end
      3, 4: begin
        idx    = gen_key_len + $urandom_range(0, 9);
        digits = $sformatf("%0d", idx);
      end
      default: begin
        idx    = (gen_key_len == 0) ? 0 : $urandom_range(0, gen_key_len - 1);
        digits = $sformatf("%0d", idx);
      end
    endcase
    if (junk) queue_item(OP_DECODE, random_letter());
    if (sel > 2 && $urandom_range(0, 7) == 0) digits = {"0", digits};
    foreach (digits[i]) queue_item(OP_DECODE, digits[i]);
    // trailing byte; after digits it ends the number and the 5 after it is ignored
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: queue_item(OP_DECODE, CH_OPEN);
        1: queue_item(OP_DECODE, CH_SPACE);
        2: queue_item(OP_DECODE, CH_MINUS);
        default: queue_item(OP_DECODE, random_letter());
      endcase
      queue_item(OP_DECODE, "5");
    end
    queue_item(OP_DECODE, CH_CLOSE);
    oob = (idx >= gen_key_len);
  endtask

  task automatic queue_message(int len);
    int         sel;
    bit         oob;
    logic [7:0] b;
    repeat (len) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_OPEN);
        queue_item(OP_DECODE, b);
      end else if (sel < 88) begin
        queue_bracket(oob);
        if (oob || $urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(0, 3)) queue_item(OP_DECODE, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 4) != 0) queue_item(OP_RESTART, 8'($urandom_range(0, 255)));
        end
      end else if (sel < 93) begin
        queue_item(OP_RESTART, 8'($urandom_range(0, 255)));
      end else if (sel < 97) begin
        // bracket left open; what follows becomes its content
        queue_item(OP_DECODE, CH_OPEN);
        repeat ($urandom_range(1, 3)) queue_item(OP_DECODE, CH_D0 + 8'($urandom_range(0, 9)));
      end else begin
        queue_item(bcid_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, bit long_key);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = n_queued + ITEMS_PER_PHASE;
    if (long_key) queue_key(LONG_KEY_LEN);
    while (n_queued < target) begin
      if ($urandom_range(0, 99) < ((gen_key_len == 0) ? 80 : (long_key ? 2 : 12)))
        queue_key(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60));
      queue_message($urandom_range(10, 60));
      queue_item(OP_RESTART, 8'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  // driver; the predictor runs on each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= OP_CLEAR;
      in_tdata  <= '0;
      key_len = '0;
      clear_parser();
    end else begin
      if (in_tvalid && in_tready) begin
        decode_step(bcid_op_t'(in_tuser), in_tdata);
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_out = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= item_out.op;
          in_tdata  <= item_out.data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected result char=%02h bad=%0b",
                                    out_tdata, out_tuser));
        end else begin
          got_char = expected_chars.pop_front();
          n_results++;
          if (got_char.bad) n_bad++;
          if (out_tdata !== got_char.chr)
            report_mismatch($sformatf("out_char %02h, expected %02h", out_tdata, got_char.chr));
          if (out_tuser !== got_char.bad)
            report_mismatch($sformatf("bad_index %0b, expected %0b", out_tuser, got_char.bad));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_chars.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 32;
    recv_idle_pct = 69;

    // pass-through extremes, error on empty key, silence until restart
    queue_item(OP_DECODE, "x");
    queue_item(OP_DECODE, 8'h00);
    queue_item(OP_DECODE, 8'hFF);
    queue_item(OP_DECODE, CH_CLOSE);
    queue_text("[]q");
    queue_item(OP_RESTART, 8'hFF);
    // key "azm": upper case folded, digit dropped
    queue_item(OP_LOAD, "A");
    queue_item(OP_LOAD, "1");
    queue_item(OP_LOAD, "z");
    queue_item(OP_LOAD, "M");
    // minus zero, blank and plus sign, index equal to key length
    queue_text("[-0][ +2][3]");
    queue_item(OP_CLEAR, 8'h00);
    wait_drained();

    run_phase(32, 69, 1'b0);
    run_phase(69, 32, 1'b0);
    run_phase(0, 0, 1'b1);

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items over three handshake pressure phases, one with a long key.",
             n_sent);
    $display("Checked %0d results, %0d of them index errors; %0d mismatches.",
             n_results, n_bad, n_mismatch);
    if (n_mismatch == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bcid_pkg.sv
hw/rtl/bcid_ram.sv
hw/rtl/book_cipher_index_decoder.sv
dv/tb_book_cipher_index_decoder.sv
